### design/assert_macros.svh
// Assertion macros shared by the allocator RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while in reset.
`define ASSERT_SAME(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled while in reset.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

### design/ffa_pkg.sv
// Shared constants, codes and types of the free-list allocator.
package ffa_pkg;

  localparam int N  = 1024;
  localparam int CW = $clog2(N + 1);
  localparam int TW = $clog2(N);

  localparam logic [31:0] PAGE_ADD  = 32'h0000_0fff;
  localparam logic [31:0] PAGE_MASK = 32'hffff_f000;

  localparam logic OP_ALLOC = 1'b0;
  localparam logic OP_FREE  = 1'b1;

  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_NOFIT = 2'd1;
  localparam logic [1:0] ST_LOST  = 2'd2;

  typedef struct packed {
    logic [31:0] base;
    logic [31:0] len;
  } entry_t;

  typedef struct packed {
    logic        op;
    logic        rnd;
    logic [31:0] address;
    logic [31:0] size;
  } req_t;

  typedef struct packed {
    logic [31:0] alloc_address;
    logic [1:0]  status;
    logic [31:0] total_free;
    logic [10:0] entry_count;
    logic [10:0] peak_entries;
    logic [31:0] lost_count;
    logic [31:0] lost_bytes;
  } res_t;

endpackage

### design/ffa_cell.sv
// One table slot: holds a region entry and passes it to its neighbor on shift.
module ffa_cell (
  input  logic           clk,
  input  logic           shift_en,
  input  ffa_pkg::entry_t d,
  output ffa_pkg::entry_t q
);

  ffa_pkg::entry_t q_r;

  // Advance the entry one slot toward the head
  always_ff @(posedge clk) begin
    if (shift_en) begin
      q_r <= d;
    end
  end

  assign q = q_r;

endmodule

### design/ffa_ctrl.sv
// Head of the ring: scans the table, then rewrites it with the edit applied.
module ffa_ctrl (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            start,
  input  ffa_pkg::req_t   req,
  input  logic            res_ready,
  input  ffa_pkg::entry_t cur,
  input  ffa_pkg::entry_t nxt,
  output logic            busy,
  output logic            done,
  output ffa_pkg::res_t   res,
  output logic            shift_en,
  output ffa_pkg::entry_t wdata
);

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_SCAN = 2'd1;
  localparam logic [1:0] S_EDIT = 2'd2;
  localparam logic [1:0] S_DONE = 2'd3;

  logic [1:0]              state_r, state_nxt;
  logic [ffa_pkg::TW-1:0]  t_r, t_nxt;
  logic [ffa_pkg::CW-1:0]  idx_r, idx_nxt;
  logic [ffa_pkg::CW-1:0]  n_r, n_nxt;
  logic [ffa_pkg::CW-1:0]  peak_r, peak_nxt;
  logic                    op_r, op_nxt;
  logic [31:0]             addr_r, addr_nxt;
  logic [31:0]             size_r, size_nxt;
  logic                    hit_r, hit_nxt;
  logic                    merged_r, merged_nxt;
  logic                    del_r, del_nxt;
  logic                    ins_r, ins_nxt;
  logic                    took_r, took_nxt;
  logic                    drop_r, drop_nxt;
  logic [31:0]             aaddr_r, aaddr_nxt;
  logic [31:0]             total_r, total_nxt;
  logic [31:0]             lcnt_r, lcnt_nxt;
  logic [31:0]             lbytes_r, lbytes_nxt;
  ffa_pkg::entry_t         last_r, last_nxt;

  logic                    last;
  logic [ffa_pkg::CW-1:0]  t_ext;
  logic                    in_tbl;
  logic                    cond;
  logic                    hit_now;
  logic                    at_prev;
  logic                    at_idx;
  logic                    merged_now;
  logic                    both_now;
  logic                    take_next;
  logic                    take_ins;
  logic                    alloc_hit;
  logic [31:0]             a_len;
  logic [31:0]             rsize;

  // Decode the current slot against the pending request
  always_comb begin
    last       = (t_r == ffa_pkg::TW'(ffa_pkg::N - 1));
    t_ext      = ffa_pkg::CW'(t_r);
    in_tbl     = (t_ext < n_r);
    cond       = (op_r == ffa_pkg::OP_ALLOC) ? (cur.len >= size_r) : (cur.base > addr_r);
    hit_now    = (state_r == S_SCAN) && !hit_r && in_tbl && cond;
    at_prev    = (state_r == S_EDIT) && (op_r == ffa_pkg::OP_FREE) &&
                 (t_ext + ffa_pkg::CW'(1) == idx_r);
    at_idx     = (state_r == S_EDIT) && (t_ext == idx_r);
    merged_now = at_prev && (cur.base + cur.len == addr_r);
    both_now   = merged_now && (idx_r < n_r) && (addr_r + size_r == nxt.base);
    take_next  = at_idx && (op_r == ffa_pkg::OP_FREE) && !merged_r && (idx_r < n_r) &&
                 (addr_r + size_r == cur.base);
    take_ins   = at_idx && (op_r == ffa_pkg::OP_FREE) && !merged_r && !take_next &&
                 (n_r < ffa_pkg::CW'(ffa_pkg::N));
    alloc_hit  = at_idx && (op_r == ffa_pkg::OP_ALLOC) && hit_r;
    a_len      = cur.len - size_r;
    rsize      = req.rnd ? ((req.size + ffa_pkg::PAGE_ADD) & ffa_pkg::PAGE_MASK) : req.size;
  end

  // Pick the entry written back into the ring
  always_comb begin
    wdata = cur;
    if (state_r == S_EDIT) begin
      if (ins_r) begin
        wdata = last_r;
      end else if (del_r) begin
        wdata = nxt;
      end
      if (alloc_hit) begin
        if (a_len == 32'd0) begin
          wdata = nxt;
        end else begin
          wdata.base = cur.base + size_r;
          wdata.len  = a_len;
        end
      end
      if (merged_now) begin
        wdata.base = cur.base;
        wdata.len  = both_now ? (cur.len + size_r + nxt.len) : (cur.len + size_r);
      end
      if (take_next) begin
        wdata.base = addr_r;
        wdata.len  = cur.len + size_r;
      end
      if (take_ins) begin
        wdata.base = addr_r;
        wdata.len  = size_r;
      end
    end
  end

  // Next state of the sequencer and the table bookkeeping
  always_comb begin
    state_nxt  = state_r;
    t_nxt      = t_r;
    idx_nxt    = idx_r;
    n_nxt      = n_r;
    peak_nxt   = peak_r;
    op_nxt     = op_r;
    addr_nxt   = addr_r;
    size_nxt   = size_r;
    hit_nxt    = hit_r;
    merged_nxt = merged_r;
    del_nxt    = del_r;
    ins_nxt    = ins_r;
    took_nxt   = took_r;
    drop_nxt   = drop_r;
    aaddr_nxt  = aaddr_r;
    total_nxt  = total_r;
    lcnt_nxt   = lcnt_r;
    lbytes_nxt = lbytes_r;
    last_nxt   = last_r;
    case (state_r)
      S_IDLE: begin
        if (start) begin
          op_nxt     = req.op;
          addr_nxt   = req.address;
          size_nxt   = rsize;
          hit_nxt    = 1'b0;
          merged_nxt = 1'b0;
          del_nxt    = 1'b0;
          ins_nxt    = 1'b0;
          took_nxt   = 1'b0;
          drop_nxt   = 1'b0;
          aaddr_nxt  = 32'd0;
          t_nxt      = '0;
          state_nxt  = S_SCAN;
        end
      end
      S_SCAN: begin
        if (hit_now) begin
          hit_nxt = 1'b1;
          idx_nxt = t_ext;
        end
        t_nxt = t_r + ffa_pkg::TW'(1);
        if (last) begin
          if (!hit_r && !hit_now) begin
            idx_nxt = n_r;
          end
          t_nxt     = '0;
          state_nxt = S_EDIT;
        end
      end
      S_EDIT: begin
        last_nxt = cur;
        if (alloc_hit) begin
          aaddr_nxt = cur.base;
          total_nxt = total_r - size_r;
          if (a_len == 32'd0) begin
            del_nxt = 1'b1;
            n_nxt   = n_r - ffa_pkg::CW'(1);
          end
        end
        if (merged_now) begin
          merged_nxt = 1'b1;
          total_nxt  = total_r + size_r;
          if (both_now) begin
            del_nxt = 1'b1;
            n_nxt   = n_r - ffa_pkg::CW'(1);
          end
        end
        if (take_next) begin
          took_nxt  = 1'b1;
          total_nxt = total_r + size_r;
        end
        if (take_ins) begin
          took_nxt  = 1'b1;
          ins_nxt   = 1'b1;
          total_nxt = total_r + size_r;
          n_nxt     = n_r + ffa_pkg::CW'(1);
          if (peak_r < n_r + ffa_pkg::CW'(1)) begin
            peak_nxt = n_r + ffa_pkg::CW'(1);
          end
        end
        t_nxt = t_r + ffa_pkg::TW'(1);
        if (last) begin
          // Drop the free when it neither merged nor found room
          if ((op_r == ffa_pkg::OP_FREE) && !merged_r && !took_r && !merged_now &&
              !take_next && !take_ins) begin
            drop_nxt   = 1'b1;
            lcnt_nxt   = lcnt_r + 32'd1;
            lbytes_nxt = lbytes_r + size_r;
          end
          t_nxt     = '0;
          state_nxt = S_DONE;
        end
      end
      S_DONE: begin
        if (res_ready) begin
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // Control and counters
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= S_IDLE;
      t_r      <= '0;
      n_r      <= '0;
      peak_r   <= '0;
      total_r  <= 32'd0;
      lcnt_r   <= 32'd0;
      lbytes_r <= 32'd0;
      hit_r    <= 1'b0;
      merged_r <= 1'b0;
      del_r    <= 1'b0;
      ins_r    <= 1'b0;
      took_r   <= 1'b0;
      drop_r   <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      t_r      <= t_nxt;
      n_r      <= n_nxt;
      peak_r   <= peak_nxt;
      total_r  <= total_nxt;
      lcnt_r   <= lcnt_nxt;
      lbytes_r <= lbytes_nxt;
      hit_r    <= hit_nxt;
      merged_r <= merged_nxt;
      del_r    <= del_nxt;
      ins_r    <= ins_nxt;
      took_r   <= took_nxt;
      drop_r   <= drop_nxt;
    end
  end

  // Request payload and scratch entries
  always_ff @(posedge clk) begin
    idx_r   <= idx_nxt;
    op_r    <= op_nxt;
    addr_r  <= addr_nxt;
    size_r  <= size_nxt;
    aaddr_r <= aaddr_nxt;
    last_r  <= last_nxt;
  end

  assign busy     = (state_r != S_IDLE);
  assign done     = (state_r == S_DONE) && res_ready;
  assign shift_en = (state_r == S_SCAN) || (state_r == S_EDIT);

  // Assemble the result of the finished request
  always_comb begin
    res.alloc_address = aaddr_r;
    if (op_r == ffa_pkg::OP_ALLOC) begin
      res.status = hit_r ? ffa_pkg::ST_OK : ffa_pkg::ST_NOFIT;
    end else begin
      res.status = drop_r ? ffa_pkg::ST_LOST : ffa_pkg::ST_OK;
    end
    res.total_free   = total_r;
    res.entry_count  = 11'(n_r);
    res.peak_entries = 11'(peak_r);
    res.lost_count   = lcnt_r;
    res.lost_bytes   = lbytes_r;
  end

endmodule

### design/first_fit_free_list_allocator.sv
// Top level of the first-fit free-list allocator with coalescing.
//
//   channel  direction  handshake           payload
//   in_      input      in_valid/in_stall   operation, round_to_page, address, size
//   out_     output     out_valid/out_stall alloc_address, status, total_free, counts
//
// Each transaction runs through the table, which lives in a ring of 1024 cells
// that rotates once to search and once more to rewrite with the edit applied.
// Reset (rst_n low, synchronous) empties the table at once; slot contents need no clear.
// A new transaction is taken while the previous result waits in the output register;
// a stalled result holds the block in its final state until out_stall drops.
module first_fit_free_list_allocator (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic        in_operation,
  input  logic        in_round_to_page,
  input  logic [31:0] in_address,
  input  logic [31:0] in_size,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [31:0] out_alloc_address,
  output logic [1:0]  out_status,
  output logic [31:0] out_total_free,
  output logic [10:0] out_entry_count,
  output logic [10:0] out_peak_entries,
  output logic [31:0] out_lost_count,
  output logic [31:0] out_lost_bytes
);

  `include "assert_macros.svh"

  ffa_pkg::entry_t cell_q [ffa_pkg::N];
  ffa_pkg::entry_t wdata;
  ffa_pkg::req_t   req;
  ffa_pkg::res_t   res;
  ffa_pkg::res_t   res_r;
  logic            out_valid_r;
  logic            busy;
  logic            done;
  logic            shift_en;
  logic            accept;
  logic            res_ready;

  assign accept    = in_valid && !in_stall;
  assign res_ready = !out_valid_r || !out_stall;
  assign in_stall  = busy;

  assign req.op      = in_operation;
  assign req.rnd     = in_round_to_page;
  assign req.address = in_address;
  assign req.size    = in_size;

  // Ring of table slots, the last one fed from the head
  for (genvar k = 0; k < ffa_pkg::N; k++) begin : g_cell
    if (k == ffa_pkg::N - 1) begin : g_tail
      ffa_cell u_cell (.clk(clk), .shift_en(shift_en), .d(wdata), .q(cell_q[k]));
    end else begin : g_body
      ffa_cell u_cell (.clk(clk), .shift_en(shift_en), .d(cell_q[k+1]), .q(cell_q[k]));
    end
  end

  ffa_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (accept),
    .req      (req),
    .res_ready(res_ready),
    .cur      (cell_q[0]),
    .nxt      (cell_q[1]),
    .busy     (busy),
    .done     (done),
    .res      (res),
    .shift_en (shift_en),
    .wdata    (wdata)
  );

  // Hold the result until the sink takes it
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (done) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (done) begin
      res_r <= res;
    end
  end

  assign out_valid         = out_valid_r;
  assign out_alloc_address = res_r.alloc_address;
  assign out_status        = res_r.status;
  assign out_total_free    = res_r.total_free;
  assign out_entry_count   = res_r.entry_count;
  assign out_peak_entries  = res_r.peak_entries;
  assign out_lost_count    = res_r.lost_count;
  assign out_lost_bytes    = res_r.lost_bytes;

  `ASSERT_NEXT(a_busy_after_accept, clk, rst_n, accept, in_stall, "no stall after accept")
  `ASSERT_SAME(a_done_only_busy, clk, rst_n, done, busy, "result while idle")
  `ASSERT_NEXT(a_done_loads_out, clk, rst_n, done, out_valid, "result not presented")
  `ASSERT_SAME(a_peak_bound, clk, rst_n, out_valid,
    out_entry_count <= out_peak_entries, "entry count above peak")

endmodule

### tb/tb_top.sv
// Self-checking testbench for the first-fit free-list allocator.
`timescale 1ns / 100ps

module tb_top;

  logic        clk;
  logic        rst_n;
  logic        in_valid;
  logic        in_stall;
  logic        in_operation;
  logic        in_round_to_page;
  logic [31:0] in_address;
  logic [31:0] in_size;
  logic        out_valid;
  logic        out_stall;
  logic [31:0] out_alloc_address;
  logic [1:0]  out_status;
  logic [31:0] out_total_free;
  logic [10:0] out_entry_count;
  logic [10:0] out_peak_entries;
  logic [31:0] out_lost_count;
  logic [31:0] out_lost_bytes;

  first_fit_free_list_allocator u_dut (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_stall          (in_stall),
    .in_operation      (in_operation),
    .in_round_to_page  (in_round_to_page),
    .in_address        (in_address),
    .in_size           (in_size),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .out_alloc_address (out_alloc_address),
    .out_status        (out_status),
    .out_total_free    (out_total_free),
    .out_entry_count   (out_entry_count),
    .out_peak_entries  (out_peak_entries),
    .out_lost_count    (out_lost_count),
    .out_lost_bytes    (out_lost_bytes)
  );

  // Shadow copy of the free-region table and its counters
  logic [31:0] shadow_base [ffa_pkg::N];
  logic [31:0] shadow_len  [ffa_pkg::N];
  int          shadow_used;
  int          shadow_peak;
  logic [31:0] shadow_lost_cnt;
  logic [31:0] shadow_lost_bytes;
  logic [31:0] shadow_free_total;

  ffa_pkg::res_t   expected_results[$];
  ffa_pkg::entry_t held_blocks[$];
  int     fail_count;
  int     checked_count;
  int     sent_count;
  int     send_idle_pct;
  int     recv_idle_pct;
  int     recv_hold_cycles;

  // Clock
  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // Remove one table slot, closing the gap
  function automatic void close_slot(input int idx);
    int k;
    for (k = idx; k + 1 < shadow_used; k++) begin
      shadow_base[k] = shadow_base[k + 1];
      shadow_len[k]  = shadow_len[k + 1];
    end
    shadow_used--;
  endfunction

  // Serve one request against the shadow table and return its result
  function automatic ffa_pkg::res_t model_request(input logic op, input logic rnd,
                                         input logic [31:0] addr, input logic [31:0] sz_in,
                                         output logic [31:0] eff_size);
    ffa_pkg::res_t r;
    int          i;
    int          j;
    int          n;
    logic [31:0] sz;
    logic [31:0] got;
    logic [1:0]  st;
    logic        done;
    sz   = rnd ? ((sz_in + ffa_pkg::PAGE_ADD) & ffa_pkg::PAGE_MASK) : sz_in;
    got  = '0;
    done = 1'b0;
    if (op == ffa_pkg::OP_ALLOC) begin
      st = ffa_pkg::ST_NOFIT;
      for (i = 0; i < shadow_used && !done; i++) begin
        if (shadow_len[i] >= sz) begin
          got               = shadow_base[i];
          shadow_base[i]    = shadow_base[i] + sz;
          shadow_len[i]     = shadow_len[i] - sz;
          shadow_free_total = shadow_free_total - sz;
          if (shadow_len[i] == 0) close_slot(i);
          st   = ffa_pkg::ST_OK;
          done = 1'b1;
        end
      end
    end else begin
      n = shadow_used;
      for (i = 0; i < n; i++) begin
        if (shadow_base[i] > addr) break;
      end
      st = ffa_pkg::ST_OK;
      if (i > 0 && 32'(shadow_base[i - 1] + shadow_len[i - 1]) == addr) begin
        shadow_len[i - 1] = shadow_len[i - 1] + sz;
        if (i < n && 32'(addr + sz) == shadow_base[i]) begin
          shadow_len[i - 1] = shadow_len[i - 1] + shadow_len[i];
          close_slot(i);
        end
        shadow_free_total = shadow_free_total + sz;
      end else if (i < n && 32'(addr + sz) == shadow_base[i]) begin
        shadow_base[i]    = addr;
        shadow_len[i]     = shadow_len[i] + sz;
        shadow_free_total = shadow_free_total + sz;
      end else if (n < ffa_pkg::N) begin
        for (j = n; j > i; j--) begin
          shadow_base[j] = shadow_base[j - 1];
          shadow_len[j]  = shadow_len[j - 1];
        end
        shadow_used = n + 1;
        if (shadow_peak < shadow_used) shadow_peak = shadow_used;
        shadow_base[i]    = addr;
        shadow_len[i]     = sz;
        shadow_free_total = shadow_free_total + sz;
      end else begin
        shadow_lost_cnt   = shadow_lost_cnt + 1;
        shadow_lost_bytes = shadow_lost_bytes + sz;
        st = ffa_pkg::ST_LOST;
      end
    end
    eff_size        = sz;
    r.alloc_address = got;
    r.status        = st;
    r.total_free    = shadow_free_total;
    r.entry_count   = 11'(shadow_used);
    r.peak_entries  = 11'(shadow_peak);
    r.lost_count    = shadow_lost_cnt;
    r.lost_bytes    = shadow_lost_bytes;
    return r;
  endfunction

  // Offer one transaction, wait for acceptance, then predict its result
  task automatic send_request(input logic op, input logic rnd,
                              input logic [31:0] addr, input logic [31:0] sz);
    ffa_pkg::res_t r;
    logic [31:0] eff;
    @(negedge clk);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid         <= 1'b1;
    in_operation     <= op;
    in_round_to_page <= rnd;
    in_address       <= addr;
    in_size          <= sz;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    r = model_request(op, rnd, addr, sz, eff);
    expected_results.push_back(r);
    sent_count++;
    if (op == ffa_pkg::OP_ALLOC && r.status == ffa_pkg::ST_OK && eff != 0)
      held_blocks.push_back('{base: r.alloc_address, len: eff});
  endtask

  // Drop valid and wait for every outstanding result
  task automatic drain;
    @(negedge clk);
    in_valid <= 1'b0;
    while (expected_results.size() != 0) @(negedge clk);
  endtask

  // Receiver stall: random idling, or a counted long hold
  always @(negedge clk) begin
    if (recv_hold_cycles > 0) begin
      out_stall        <= 1'b1;
      recv_hold_cycles <= recv_hold_cycles - 1;
    end else begin
      out_stall <= ($urandom_range(99) < recv_idle_pct);
    end
  end

  // Compare each accepted result with the oldest expectation
  always @(posedge clk) begin
    ffa_pkg::res_t e;
    if (rst_n && out_valid && !out_stall) begin
      if (expected_results.size() == 0) begin
        $error("unexpected result transaction");
        fail_count++;
      end else begin
        e = expected_results.pop_front();
        checked_count++;
        if (out_alloc_address !== e.alloc_address) begin
          $error("alloc_address exp %h got %h", e.alloc_address, out_alloc_address);
          fail_count++;
        end
        if (out_status !== e.status) begin
          $error("status exp %0d got %0d", e.status, out_status);
          fail_count++;
        end
        if (out_total_free !== e.total_free) begin
          $error("total_free exp %h got %h", e.total_free, out_total_free);
          fail_count++;
        end
        if (out_entry_count !== e.entry_count) begin
          $error("entry_count exp %0d got %0d", e.entry_count, out_entry_count);
          fail_count++;
        end
        if (out_peak_entries !== e.peak_entries) begin
          $error("peak_entries exp %0d got %0d", e.peak_entries, out_peak_entries);
          fail_count++;
        end
        if (out_lost_count !== e.lost_count) begin
          $error("lost_count exp %h got %h", e.lost_count, out_lost_count);
          fail_count++;
        end
        if (out_lost_bytes !== e.lost_bytes) begin
          $error("lost_bytes exp %h got %h", e.lost_bytes, out_lost_bytes);
          fail_count++;
        end
      end
    end
  end

  // Corner cases: empty table, zero sizes, merges, wrap and page rounding
  task automatic test_corner_cases;
    send_request(ffa_pkg::OP_ALLOC, 1'b0, 32'h0, 32'h10);
    send_request(ffa_pkg::OP_FREE,  1'b0, 32'h0, 32'h0);
    send_request(ffa_pkg::OP_ALLOC, 1'b0, 32'hdead_beef, 32'h0);
    send_request(ffa_pkg::OP_FREE,  1'b0, 32'h0000_2000, 32'h1000);
    send_request(ffa_pkg::OP_FREE,  1'b0, 32'h0000_3000, 32'h0800);
    send_request(ffa_pkg::OP_FREE,  1'b0, 32'h0000_1000, 32'h1000);
    send_request(ffa_pkg::OP_FREE,  1'b0, 32'h0000_5000, 32'h1000);
    send_request(ffa_pkg::OP_FREE,  1'b0, 32'h0000_3800, 32'h1800);
    send_request(ffa_pkg::OP_FREE,  1'b0, 32'h0000_0000, 32'h1000);
    send_request(ffa_pkg::OP_ALLOC, 1'b0, 32'h0, 32'h100);
    send_request(ffa_pkg::OP_ALLOC, 1'b1, 32'h0, 32'h1);
    send_request(ffa_pkg::OP_ALLOC, 1'b1, 32'h0, 32'hffff_ffff);
    send_request(ffa_pkg::OP_ALLOC, 1'b0, 32'h0, 32'hffff_ffff);
    send_request(ffa_pkg::OP_FREE,  1'b0, 32'hffff_f000, 32'h1000);
    send_request(ffa_pkg::OP_FREE,  1'b0, 32'h8000_0000, 32'h0);
    send_request(ffa_pkg::OP_FREE,  1'b0, 32'h0000_2000, 32'h0100);
    send_request(ffa_pkg::OP_FREE,  1'b1, 32'h7fff_0000, 32'hffff_f001);
    send_request(ffa_pkg::OP_ALLOC, 1'b0, 32'h0, 32'h0);
    send_request(ffa_pkg::OP_ALLOC, 1'b1, 32'h0, 32'h0000_1000);
    send_request(ffa_pkg::OP_ALLOC, 1'b0, 32'h0, 32'h0000_6f00);
    drain();
  endtask

  // Mostly alloc/free pairs on a seeded pool, with some raw noise
  task automatic test_random_traffic(input int count);
    int              k;
    int              pick;
    int              idx;
    ffa_pkg::entry_t blk;
    logic [31:0]     sz;
    send_request(ffa_pkg::OP_FREE, 1'b0, 32'h1000_0000 + ($urandom_range(255) << 16),
                 32'h0100_0000);
    for (k = 0; k < count; k++) begin
      pick = $urandom_range(99);
      if (pick < 45 && held_blocks.size() != 0) begin
        idx = $urandom_range(held_blocks.size() - 1);
        blk = held_blocks[idx];
        held_blocks.delete(idx);
        send_request(ffa_pkg::OP_FREE, 1'b0, blk.base, blk.len);
      end else if (pick < 85) begin
        sz = ($urandom_range(9) == 0) ? $urandom_range(32'h0004_0000, 1) :
             $urandom_range(4096, 1);
        send_request(ffa_pkg::OP_ALLOC, 1'($urandom_range(1)), $urandom(), sz);
      end else begin
        send_request(1'($urandom_range(1)), 1'($urandom_range(1)), $urandom(), $urandom());
      end
    end
    drain();
  endtask

  // Hold the receiver off for a long stretch while requests keep coming
  task automatic test_output_backpressure;
    int k;
    @(negedge clk);
    recv_hold_cycles <= 6000;
    for (k = 0; k < 5; k++)
      send_request(ffa_pkg::OP_ALLOC, 1'b0, $urandom(), $urandom_range(64, 1));
    drain();
  endtask

  // Watchdog
  initial begin
    #40_000_000;
    $display("tb: failure");
    $finish;
  end

  // Sequence of tests
  initial begin
    rst_n            = 1'b0;
    in_valid         = 1'b0;
    in_operation     = ffa_pkg::OP_ALLOC;
    in_round_to_page = 1'b0;
    in_address       = '0;
    in_size          = '0;
    out_stall        = 1'b0;
    recv_hold_cycles = 0;
    send_idle_pct    = 0;
    recv_idle_pct    = 0;
    fail_count       = 0;
    checked_count    = 0;
    sent_count       = 0;
    shadow_used       = 0;
    shadow_peak       = 0;
    shadow_lost_cnt   = '0;
    shadow_lost_bytes = '0;
    shadow_free_total = '0;
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    send_idle_pct = 31;
    recv_idle_pct = 87;
    test_corner_cases();
    test_random_traffic(85);
    send_idle_pct = 87;
    recv_idle_pct = 31;
    test_random_traffic(85);
    send_idle_pct = 0;
    recv_idle_pct = 0;
    test_random_traffic(85);
    test_output_backpressure();

    repeat (2200) @(posedge clk);
    $display("tb: %0d transactions sent, %0d results checked, peak table use %0d",
             sent_count, checked_count, shadow_peak);
    $display("tb: covered merges, zero sizes, page rounding, wrap and output hold-off");
    if (fail_count == 0 && expected_results.size() == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
